[rtl/core/adc_ramp_pattern_checker_defines.svh]
// Assertion macros used by the ramp checker assertion module.
`ifndef ADC_RAMP_PATTERN_CHECKER_DEFINES_SVH
`define ADC_RAMP_PATTERN_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARPC_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("ramp checker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ARPC_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("ramp checker assertion failed");

// Next-cycle implication that is also checked across reset.
`define ARPC_ASSERT_RST(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) (cond) |=> (prop)) \
        else $error("ramp checker reset assertion failed");

`endif

[rtl/core/arpc_pkg.sv]
package arpc_pkg;

    // Field widths of the data stream.
    localparam int SAMPLE_W = 16;
    localparam int PULSE_W  = 56;

    // Skip-word marker and count field.
    localparam int SKIP_BIT = 15;

    // Saturation limits of the leading-skip and in-record skip sums.
    localparam logic [23:0] LEAD_MAX = 24'hFF_FFFF;
    localparam logic [16:0] SKIP_MAX = 17'h1_FFFF;

    // Reset value of the pulse step register.
    localparam logic [15:0] PULSE_STEP_RESET = 16'd1348;

    // Record kind carried by the func field.
    typedef enum logic {
        REC_RAW = 1'b0,
        REC_FEX = 1'b1
    } t_rec_kind;

    // One input word with its record framing.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                func;
        logic                first;
        logic                last;
        logic [PULSE_W-1:0]  pulse_id;
    } t_word;

    // One record result.
    typedef struct packed {
        logic kind;
        logic checked;
        logic initial_error;
        logic internal_error;
    } t_result;

endpackage

[rtl/core/arpc_in_stage.sv]
module arpc_in_stage
    import arpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_word i_word,
    input  logic  i_space,
    output logic  o_ready,
    output logic  o_fire,
    output t_word o_word
);

    logic  r_valid;
    t_word r_word;

    // A word leaves the register when it makes no result or the result slot is free.
    assign o_fire  = r_valid && (!r_word.last || i_space);
    assign o_ready = !r_valid || o_fire;
    assign o_word  = r_word;

    // Valid flag of the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the input register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

[rtl/core/arpc_engine.sv]
module arpc_engine
    import arpc_pkg::*;
#(
    parameter int GROUP_SIZE   = 4,
    parameter int PATTERN_BITS = 11
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_fire,
    input  t_word       i_word,
    output t_result     o_result
);

    localparam int          GPOS_W    = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam logic [GPOS_W-1:0] GPOS_LAST = GPOS_W'(GROUP_SIZE - 1);
    localparam logic [15:0] PMASK     = 16'((32'd1 << PATTERN_BITS) - 32'd1);

    logic [15:0]        r_pulse_step;
    logic [15:0]        r_ref_value,  n_ref_value;
    logic [PULSE_W-1:0] r_prev_pulse, n_prev_pulse;
    logic               r_have_ref,   n_have_ref;
    logic [15:0]        r_expected,   n_expected;
    logic [GPOS_W-1:0]  r_group_pos,  n_group_pos;
    logic               r_group_failed, n_group_failed;
    logic               r_skip_group, n_skip_group;
    logic [16:0]        r_skip_sum,   n_skip_sum;
    logic [23:0]        r_lead_sum,   n_lead_sum;
    logic               r_in_lead,    n_in_lead;
    logic               r_stopped,    n_stopped;
    logic               r_err_init,   n_err_init;
    logic               r_err_int,    n_err_int;
    logic               r_err_chk,    n_err_chk;

    logic [15:0] w;
    logic [15:0] pid_diff;
    logic [15:0] pid_prod;
    logic [15:0] pred_raw;

    assign w = i_word.sample;

    // Raw prediction: reference plus pulse difference times step, all modulo 2^16.
    assign pid_diff = i_word.pulse_id[15:0] - r_prev_pulse[15:0];
    assign pid_prod = pid_diff * r_pulse_step;
    assign pred_raw = r_ref_value + pid_prod;

    // Next state for one word.
    always_comb begin
        logic        do_close;
        logic [24:0] lead_tmp;
        logic [17:0] skip_tmp;
        logic [15:0] pred_fex;

        n_ref_value    = r_ref_value;
        n_prev_pulse   = r_prev_pulse;
        n_have_ref     = r_have_ref;
        n_expected     = r_expected;
        n_group_pos    = r_group_pos;
        n_group_failed = r_group_failed;
        n_skip_group   = r_skip_group;
        n_skip_sum     = r_skip_sum;
        n_lead_sum     = r_lead_sum;
        n_in_lead      = r_in_lead;
        n_stopped      = r_stopped;
        n_err_init     = r_err_init;
        n_err_int      = r_err_int;
        n_err_chk      = r_err_chk;
        do_close       = 1'b0;
        lead_tmp       = '0;
        skip_tmp       = '0;
        pred_fex       = '0;

        if (i_word.func == REC_RAW) begin
            // Raw record word.
            if (i_word.first) begin
                n_err_init     = 1'b0;
                n_err_int      = 1'b0;
                n_err_chk      = 1'b0;
                n_in_lead      = 1'b0;
                n_stopped      = 1'b0;
                n_skip_group   = 1'b0;
                n_group_pos    = '0;
                n_group_failed = 1'b0;
                if (r_have_ref) begin
                    n_err_chk = 1'b1;
                    if ((pred_raw & PMASK) != w) begin
                        n_err_init = 1'b1;
                    end
                end
                n_expected   = w;
                n_ref_value  = w;
                n_prev_pulse = i_word.pulse_id;
                n_have_ref   = 1'b1;
            end
            if (n_err_chk) begin
                if (!n_group_failed && ((n_expected & PMASK) != w)) begin
                    n_group_failed = 1'b1;
                    n_err_int      = 1'b1;
                end
                do_close = 1'b1;
            end
        end else begin
            // Fex record word.
            if (i_word.first) begin
                n_err_init     = 1'b0;
                n_err_int      = 1'b0;
                n_err_chk      = 1'b0;
                n_in_lead      = 1'b1;
                n_lead_sum     = '0;
                n_stopped      = 1'b0;
                n_skip_group   = 1'b0;
                n_group_pos    = '0;
                n_group_failed = 1'b0;
            end
            if (n_in_lead && w[SKIP_BIT]) begin
                // Leading skip word: count plus one, saturating.
                lead_tmp   = {1'b0, n_lead_sum} + {10'd0, w[SKIP_BIT-1:0]} + 25'd1;
                n_lead_sum = (lead_tmp > {1'b0, LEAD_MAX}) ? LEAD_MAX : lead_tmp[23:0];
            end else begin
                if (n_in_lead) begin
                    // First data word after the leading skips.
                    pred_fex     = r_ref_value + n_lead_sum[17:2];
                    n_in_lead    = 1'b0;
                    n_err_chk    = 1'b1;
                    if ((pred_fex & PMASK) != w) begin
                        n_err_init = 1'b1;
                    end
                    n_expected   = w;
                    n_group_pos  = '0;
                    n_skip_group = 1'b0;
                end
                if (!n_stopped && n_err_chk) begin
                    if ((n_group_pos == '0) && w[SKIP_BIT]) begin
                        n_skip_group = 1'b1;
                        n_skip_sum   = '0;
                    end
                    if (n_skip_group) begin
                        skip_tmp   = {1'b0, n_skip_sum} + {3'd0, w[SKIP_BIT-1:0]};
                        n_skip_sum = (skip_tmp > {1'b0, SKIP_MAX}) ? SKIP_MAX
                                                                   : skip_tmp[16:0];
                        do_close   = 1'b1;
                    end else if ((n_expected & PMASK) != w) begin
                        n_err_int = 1'b1;
                        n_stopped = 1'b1;
                    end else begin
                        do_close = 1'b1;
                    end
                end
            end
        end

        // Group bookkeeping: step the ramp at the end of each group.
        if (do_close) begin
            if (n_group_pos == GPOS_LAST) begin
                n_group_pos    = '0;
                n_group_failed = 1'b0;
                if (n_skip_group) begin
                    n_expected   = n_expected + {1'b0, n_skip_sum[16:2]};
                    n_skip_group = 1'b0;
                end else begin
                    n_expected = n_expected + 16'd1;
                end
            end else begin
                n_group_pos = n_group_pos + GPOS_W'(1);
            end
        end
    end

    // Result of the word that closes a record.
    assign o_result.kind           = i_word.func;
    assign o_result.checked        = n_err_chk;
    assign o_result.initial_error  = n_err_init;
    assign o_result.internal_error = n_err_int;

    // Pulse step register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_step <= PULSE_STEP_RESET;
        end else if (i_cfg_we) begin
            r_pulse_step <= i_cfg_wdata;
        end
    end

    // Checker state, updated once per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_value    <= '0;
            r_prev_pulse   <= '0;
            r_have_ref     <= 1'b0;
            r_expected     <= '0;
            r_group_pos    <= '0;
            r_group_failed <= 1'b0;
            r_skip_group   <= 1'b0;
            r_skip_sum     <= '0;
            r_lead_sum     <= '0;
            r_in_lead      <= 1'b0;
            r_stopped      <= 1'b0;
            r_err_init     <= 1'b0;
            r_err_int      <= 1'b0;
            r_err_chk      <= 1'b0;
        end else if (i_fire) begin
            r_ref_value    <= n_ref_value;
            r_prev_pulse   <= n_prev_pulse;
            r_have_ref     <= n_have_ref;
            r_expected     <= n_expected;
            r_group_pos    <= n_group_pos;
            r_group_failed <= n_group_failed;
            r_skip_group   <= n_skip_group;
            r_skip_sum     <= n_skip_sum;
            r_lead_sum     <= n_lead_sum;
            r_in_lead      <= n_in_lead;
            r_stopped      <= n_stopped;
            r_err_init     <= n_err_init;
            r_err_int      <= n_err_int;
            r_err_chk      <= n_err_chk;
        end
    end

endmodule

[rtl/core/arpc_out_stage.sv]
module arpc_out_stage
    import arpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // The slot can take a result when empty or when its word is taken this cycle.
    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the result register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[rtl/core/adc_ramp_pattern_checker.sv]
// A result word passes through the input register and then the result register; the
// last word of a record waits in the input register while the result register is full.
// Throughput: one sample word per cycle; the input stalls only while a record's last word
// waits for the result register to be emptied.
// Reset: synchronous, active low; clears all checker state, empties both pipeline
// registers and loads the pulse step register with 1348.
module adc_ramp_pattern_checker
    import arpc_pkg::*;
#(
    parameter int GROUP_SIZE   = 4,
    parameter int PATTERN_BITS = 11
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_sample,
    input  logic               i_func,
    input  logic               i_first,
    input  logic               i_last,
    input  logic [PULSE_W-1:0] i_pulse_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic               o_checked,
    output logic               o_initial_error,
    output logic               o_internal_error
);

    t_word   in_word;
    t_word   stage_word;
    t_result eng_result;
    t_result out_result;
    logic    fire;
    logic    space;

    // Gather the input fields into one word.
    assign in_word.sample   = i_sample;
    assign in_word.func     = i_func;
    assign in_word.first    = i_first;
    assign in_word.last     = i_last;
    assign in_word.pulse_id = i_pulse_id;

    arpc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (in_word),
        .i_space (space),
        .o_ready (o_in_ready),
        .o_fire  (fire),
        .o_word  (stage_word)
    );

    arpc_engine #(
        .GROUP_SIZE   (GROUP_SIZE),
        .PATTERN_BITS (PATTERN_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_word      (stage_word),
        .o_result    (eng_result)
    );

    arpc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && stage_word.last),
        .i_result (eng_result),
        .i_ready  (i_out_ready),
        .o_space  (space),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    // Spread the result word onto its ports.
    assign o_kind           = out_result.kind;
    assign o_checked        = out_result.checked;
    assign o_initial_error  = out_result.initial_error;
    assign o_internal_error = out_result.internal_error;

endmodule

[rtl/core/arpc_checker.sv]
`include "adc_ramp_pattern_checker_defines.svh"

module arpc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_last,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_kind,
    input logic o_checked,
    input logic o_initial_error,
    input logic o_internal_error
);

    logic [3:0] result_word;
    logic       last_taken;

    // Result fields as one word, and an accepted last word of a record.
    assign result_word = {o_kind, o_checked, o_initial_error, o_internal_error};
    assign last_taken  = i_in_valid && o_in_ready && i_last;

    // A stalled result word stays valid and unchanged.
    `ARPC_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(result_word))

    // Reset leaves no result word pending.
    `ARPC_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid)

    // With an empty result slot the block always takes a new word.
    `ARPC_ASSERT_IMP(a_ready_empty, !o_out_valid, o_in_ready)

    // A new result word comes from an accepted last word, through the input and result registers.
    `ARPC_ASSERT_IMP(a_result_src, $rose(o_out_valid), $past(last_taken, 2))

endmodule

bind adc_ramp_pattern_checker arpc_checker u_arpc_checker (.*);
